>>> rtl/ewma_pkg.sv
// ----------------------------------------------------------------------------
// ewma_pkg
// Shared types and constants for the EWMA with aged minimum and maximum.
// ----------------------------------------------------------------------------
package ewma_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int AVG_W      = 32;
  localparam int AGE_W      = 8;
  localparam int ALPHA_W    = 16;
  localparam int SEQ_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 1'b1;

  // register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd32768;
  localparam logic [AGE_W-1:0]   AGE_LIMIT_RESET = 8'd3;
  localparam logic [AGE_W-1:0]   AGE_ONE         = 8'd1;
  localparam logic [AGE_W-1:0]   AGE_MAX         = 8'd255;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [AVG_W-1:0]    avg_t;
  typedef logic [AGE_W-1:0]           age_t;
  typedef logic [SEQ_W-1:0]           seq_t;

  typedef struct packed {
    seq_t    sample_number;
    sample_t running_minimum;
    avg_t    average_out;
    sample_t running_maximum;
  } result_t;

endpackage

>>> rtl/ewma_with_aged_min_max.sv
// ----------------------------------------------------------------------------
// ewma_with_aged_min_max
// Running EWMA (Q16.16) with minimum and maximum that expire after a set age.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     sample_in, start_series
//   out      output     out_valid / out_stall   sample_number, running_minimum,
//                                               average_out, running_maximum
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// One sample per clock while the input is not stalled. The statistics update
// in the cycle a beat is taken and the result goes to the output register,
// or to the skid register if the output stalls; the 33x17 multiply plus
// rounding add and saturation sets the cycle time. A skid register keeps the
// input open for one beat while the output stalls. Reset (rst, synchronous)
// clears statistics, restores register defaults and empties the output.
// ----------------------------------------------------------------------------
module ewma_with_aged_min_max (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ewma_pkg::sample_t                  sample_in,
  input  logic                               start_series,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ewma_pkg::seq_t                     sample_number,
  output ewma_pkg::sample_t                  running_minimum,
  output ewma_pkg::avg_t                     average_out,
  output ewma_pkg::sample_t                  running_maximum,
  input  logic                               cfg_write,
  input  logic [ewma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ewma_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ewma_pkg::*;

  logic [ALPHA_W-1:0] alpha;
  age_t               age_limit;

  avg_t    average_acc;
  sample_t held_minimum;
  sample_t held_maximum;
  age_t    minimum_age;
  age_t    maximum_age;
  seq_t    series_index;

  avg_t    average_acc_next;
  sample_t held_minimum_next;
  sample_t held_maximum_next;
  age_t    minimum_age_next;
  age_t    maximum_age_next;
  seq_t    series_index_next;

  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  result_t res_next;

  logic in_take;
  logic out_take;

  logic signed [AVG_W:0]     diff;
  logic signed [AVG_W+17:0]  prod;
  logic signed [AVG_W+17:0]  prod_rnd;
  logic signed [AVG_W+1:0]   delta;
  logic signed [AVG_W+2:0]   sum;
  avg_t                      ewma_sat;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      age_limit <= AGE_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ALPHA:     alpha     <= cfg_data[ALPHA_W-1:0];
        CFG_AGE_LIMIT: age_limit <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // EWMA: avg + round(alpha * (x*2^16 - avg) / 2^16), saturated
  always_comb begin
    diff     = {sample_in[SAMPLE_W-1], sample_in, 16'b0} -
               {average_acc[AVG_W-1], average_acc};
    prod     = diff * $signed({1'b0, alpha});
    prod_rnd = prod + (AVG_W+18)'(32768);
    delta    = prod_rnd[AVG_W+17:16];
    sum      = {{3{average_acc[AVG_W-1]}}, average_acc} + {delta[AVG_W+1], delta};
    if (sum[AVG_W+2:AVG_W-1] == 4'b0000 || sum[AVG_W+2:AVG_W-1] == 4'b1111) begin
      ewma_sat = sum[AVG_W-1:0];
    end else if (sum[AVG_W+2]) begin
      ewma_sat = {1'b1, {(AVG_W-1){1'b0}}};
    end else begin
      ewma_sat = {1'b0, {(AVG_W-1){1'b1}}};
    end
  end

  // statistics next state
  always_comb begin
    held_minimum_next = held_minimum;
    held_maximum_next = held_maximum;
    minimum_age_next  = minimum_age;
    maximum_age_next  = maximum_age;
    if (start_series) begin
      average_acc_next  = {sample_in, 16'b0};
      held_minimum_next = sample_in;
      held_maximum_next = sample_in;
      minimum_age_next  = AGE_ONE;
      maximum_age_next  = AGE_ONE;
      series_index_next = SEQ_W'(1);
    end else begin
      average_acc_next  = ewma_sat;
      series_index_next = series_index + SEQ_W'(1);
      // expire the held extreme once its age reaches the limit
      if (minimum_age < age_limit) begin
        if (sample_in < held_minimum) begin
          held_minimum_next = sample_in;
          minimum_age_next  = AGE_ONE;
        end else if (minimum_age != AGE_MAX) begin
          minimum_age_next = minimum_age + AGE_ONE;
        end
      end else begin
        held_minimum_next = sample_in;
        minimum_age_next  = AGE_ONE;
      end
      if (maximum_age < age_limit) begin
        if (sample_in > held_maximum) begin
          held_maximum_next = sample_in;
          maximum_age_next  = AGE_ONE;
        end else if (maximum_age != AGE_MAX) begin
          maximum_age_next = maximum_age + AGE_ONE;
        end
      end else begin
        held_maximum_next = sample_in;
        maximum_age_next  = AGE_ONE;
      end
    end
    res_next.sample_number   = series_index_next;
    res_next.running_minimum = held_minimum_next;
    res_next.average_out     = average_acc_next;
    res_next.running_maximum = held_maximum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_acc  <= '0;
      held_minimum <= '0;
      held_maximum <= '0;
      minimum_age  <= AGE_ONE;
      maximum_age  <= AGE_ONE;
      series_index <= '0;
    end else if (in_take) begin
      average_acc  <= average_acc_next;
      held_minimum <= held_minimum_next;
      held_maximum <= held_maximum_next;
      minimum_age  <= minimum_age_next;
      maximum_age  <= maximum_age_next;
      series_index <= series_index_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_take) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      // advance the skid beat, else drop valid
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      if (!out_valid || out_take) begin
        out_data <= res_next;
      end else begin
        skid_data <= res_next;
      end
    end else if (out_take && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign sample_number   = out_data.sample_number;
  assign running_minimum = out_data.running_minimum;
  assign average_out     = out_data.average_out;
  assign running_maximum = out_data.running_maximum;

endmodule

>>> rtl/ewma_chk.sv
// ----------------------------------------------------------------------------
// ewma_chk
// Port-level checks for ewma_with_aged_min_max, bound to the top level.
// ----------------------------------------------------------------------------
module ewma_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input ewma_pkg::sample_t                  sample_in,
  input logic                               start_series,
  input logic                               out_valid,
  input logic                               out_stall,
  input ewma_pkg::seq_t                     sample_number,
  input ewma_pkg::sample_t                  running_minimum,
  input ewma_pkg::avg_t                     average_out,
  input ewma_pkg::sample_t                  running_maximum,
  input logic                               cfg_write,
  input logic [ewma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [ewma_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ewma_pkg::*;

  // the held minimum never passes the held maximum: both bracket the sample
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_minimum <= running_maximum)
    else $error("minimum above maximum");

  // input only stalls when a beat waits behind the output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // empty and open right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_number) &&
      $stable(running_minimum) && $stable(average_out) &&
      $stable(running_maximum))
    else $error("stalled result changed");

endmodule

bind ewma_with_aged_min_max ewma_chk u_ewma_chk (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ewma_with_aged_min_max. A short table of directed
// samples runs first, then random sample series under several register
// settings. Every result is checked in order, against a literal result in the
// table or a local model of the running average and aged minimum and maximum.
// ----------------------------------------------------------------------------
module tb_top;
  import ewma_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int FIXED_PHASES = 5;
  localparam int RAND_PHASES  = 3;
  localparam int PHASE_ITEMS  = 85;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 64;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 460;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    sample_t sample;
    logic    start;
    logic    typed;
    result_t want;
  } dir_row_t;

  // Literal results only where they follow at a glance: first sample after
  // reset, and series starts, two of them at the sample extremes.
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{16'sd0,      1'b0, 1'b1, '{16'd1, 16'sd0, 32'sd0, 16'sd0}},
    '{16'sd1000,   1'b0, 1'b0, '0},
    '{-16'sd5,     1'b0, 1'b0, '0},
    '{16'sh8000,   1'b1, 1'b1, '{16'd1, 16'sh8000, 32'sh8000_0000, 16'sh8000}},
    '{16'sh7FFF,   1'b0, 1'b0, '0},
    '{16'sh7FFF,   1'b0, 1'b0, '0},
    '{16'sh7FFF,   1'b0, 1'b0, '0},
    '{16'sh7FFF,   1'b0, 1'b0, '0},
    '{16'sh7FFF,   1'b1, 1'b1, '{16'd1, 16'sh7FFF, 32'sh7FFF_0000, 16'sh7FFF}},
    '{16'sh8000,   1'b0, 1'b0, '0},
    '{16'sh8000,   1'b0, 1'b0, '0},
    '{16'sh8000,   1'b0, 1'b0, '0},
    '{16'sh8000,   1'b0, 1'b0, '0},
    '{16'sd0,      1'b1, 1'b1, '{16'd1, 16'sd0, 32'sd0, 16'sd0}},
    '{-16'sd1,     1'b0, 1'b0, '0},
    '{16'sd1,      1'b0, 1'b0, '0},
    '{-16'sd1,     1'b0, 1'b0, '0},
    '{16'sh5555,   1'b0, 1'b0, '0},
    '{16'shAAAA,   1'b0, 1'b0, '0},
    '{16'sd100,    1'b1, 1'b1, '{16'd1, 16'sd100, 32'sh0064_0000, 16'sd100}},
    '{16'sd90,     1'b0, 1'b0, '0},
    '{16'sd110,    1'b0, 1'b0, '0},
    '{16'sd95,     1'b0, 1'b0, '0},
    '{16'sd95,     1'b0, 1'b0, '0},
    '{16'sd95,     1'b0, 1'b0, '0}
  };

  localparam logic [ALPHA_W-1:0] PHASE_ALPHA [FIXED_PHASES] =
    '{16'd1, 16'd65535, ALPHA_RESET, 16'd1, 16'd65535};
  localparam age_t PHASE_AGE [FIXED_PHASES] =
    '{8'd1, AGE_MAX, AGE_LIMIT_RESET, AGE_MAX, 8'd1};

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  sample_t               sample_in    = '0;
  logic                  start_series = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  seq_t                  sample_number;
  sample_t               running_minimum;
  avg_t                  average_out;
  sample_t               running_maximum;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // model of the block's statistics and registers
  avg_t               avg_q       = '0;
  sample_t            min_q       = '0;
  sample_t            max_q       = '0;
  age_t               min_age_q   = AGE_ONE;
  age_t               max_age_q   = AGE_ONE;
  seq_t               index_q     = '0;
  logic [ALPHA_W-1:0] alpha_q     = ALPHA_RESET;
  age_t               age_limit_q = AGE_LIMIT_RESET;

  result_t stats_due [$];
  int      beats_in       = 0;
  int      beats_out      = 0;
  int      series_count   = 0;
  int      settings_count = 1;
  int      fail_count     = 0;
  int      hold_left      = 0;
  bit      held_once      = 1'b0;
  logic    calm           = 1'b0;

  ewma_with_aged_min_max dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void age_extreme(inout sample_t held, inout age_t age,
                                      input sample_t x, input bit is_min);
    if (age < age_limit_q) begin
      if (is_min ? (x < held) : (x > held)) begin
        held = x;
        age  = AGE_ONE;
      end else if (age != AGE_MAX) begin
        age = age + AGE_ONE;
      end
    end else begin
      held = x;
      age  = AGE_ONE;
    end
  endfunction

  function automatic result_t advance_stats(sample_t x, logic start);
    longint  diff;
    longint  sum;
    result_t r;
    if (start) begin
      avg_q     = {x, 16'h0000};
      min_q     = x;
      max_q     = x;
      min_age_q = AGE_ONE;
      max_age_q = AGE_ONE;
      index_q   = 16'd1;
    end else begin
      age_extreme(min_q, min_age_q, x, 1'b1);
      age_extreme(max_q, max_age_q, x, 1'b0);
      diff = (longint'(x) <<< 16) - longint'(avg_q);
      // round to nearest, ties up: arithmetic shift floors
      sum  = longint'(avg_q) + ((diff * longint'(alpha_q) + 64'sd32768) >>> 16);
      if (sum > 64'sd2147483647)
        sum = 64'sd2147483647;
      else if (sum < -64'sd2147483648)
        sum = -64'sd2147483648;
      avg_q   = avg_t'(sum);
      index_q = index_q + 16'd1;
    end
    r.sample_number   = index_q;
    r.running_minimum = min_q;
    r.average_out     = avg_q;
    r.running_maximum = max_q;
    return r;
  endfunction

  function automatic void check_stats(result_t got);
    result_t want;
    string   bad;
    if (stats_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("ERROR: result %0d with nothing pending: n=%0d min=%0d avg=%0d max=%0d",
                 beats_out, got.sample_number, got.running_minimum,
                 got.average_out, got.running_maximum);
      return;
    end
    want = stats_due.pop_front();
    bad  = "";
    if (got.sample_number !== want.sample_number)     bad = {bad, " sample_number"};
    if (got.running_minimum !== want.running_minimum) bad = {bad, " running_minimum"};
    if (got.average_out !== want.average_out)         bad = {bad, " average_out"};
    if (got.running_maximum !== want.running_maximum) bad = {bad, " running_maximum"};
    if (bad != "") begin
      fail_count++;
      if (fail_count <= MAX_SHOWN) begin
        $display("ERROR: result %0d wrong in%s", beats_out, bad);
        $display("  expected n=%0d min=%0d avg=%0d max=%0d", want.sample_number,
                 want.running_minimum, want.average_out, want.running_maximum);
        $display("  actual   n=%0d min=%0d avg=%0d max=%0d", got.sample_number,
                 got.running_minimum, got.average_out, got.running_maximum);
      end
    end
  endfunction

  // Check each result beat, then pick the stall for the next cycle.
  always @(posedge clk) begin : result_sink
    result_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.sample_number   = sample_number;
        got.running_minimum = running_minimum;
        got.average_out     = average_out;
        got.running_maximum = running_maximum;
        check_stats(got);
        beats_out++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_once && beats_out >= HOLD_AT) begin
        // hold off long enough for the block to back up into its input
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        held_once = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  task automatic send_beat(sample_t x, logic start, logic typed, result_t want);
    result_t predicted;
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_in    <= x;
    start_series <= start;
    do @(posedge clk); while (in_stall);
    predicted = advance_stats(x, start);
    stats_due.push_back(typed ? want : predicted);
    beats_in++;
    if (start)
      series_count++;
    calm <= (beats_in >= CALM_FIRST) && (beats_in < CALM_LAST);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (stats_due.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_settings(logic [ALPHA_W-1:0] alpha, age_t limit);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ALPHA;
    cfg_data  <= alpha;
    @(posedge clk);
    cfg_index <= CFG_AGE_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_write <= 1'b0;
    alpha_q     = alpha;
    age_limit_q = limit;
    settings_count++;
  endtask

  function automatic sample_t pick_sample(sample_t prev);
    int unsigned roll;
    int          walk;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (roll < 60) begin
      // drift near the last sample so extremes live long enough to age out
      walk = int'(prev) + int'($urandom_range(128)) - 64;
      if (walk > 32767)
        walk = 32767;
      if (walk < -32768)
        walk = -32768;
      return sample_t'(walk);
    end
    return sample_t'($urandom);
  endfunction

  task automatic run_series(int count, bit restarts);
    sample_t x;
    logic    start;
    x = sample_t'($urandom);
    for (int i = 0; i < count; i++) begin
      start = (i == 0 && $urandom_range(1) == 1) ||
              (restarts && $urandom_range(99) < 6);
      x = pick_sample(x);
      send_beat(x, start, 1'b0, '0);
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].start,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    drain();

    for (int p = 0; p < FIXED_PHASES; p++) begin
      load_settings(PHASE_ALPHA[p], PHASE_AGE[p]);
      run_series(PHASE_ITEMS, 1'b1);
    end
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_settings(ALPHA_W'($urandom_range(65535, 1)), age_t'($urandom_range(255, 1)));
      run_series(PHASE_ITEMS, 1'b1);
    end
    repeat (4) @(posedge clk);

    $display("Covered %0d samples in %0d series under %0d register settings,",
             beats_in, series_count, settings_count);
    $display("with a long output hold-off that backed the block up into its input.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches over %0d checked results", fail_count, beats_out);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ERROR: timeout with %0d results still pending", stats_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/ewma_pkg.sv
rtl/ewma_with_aged_min_max.sv
rtl/ewma_chk.sv
dv/tb_top.sv
